[hdl/wfc_pkg.sv]
// Shared types, widths and color-ramp functions for the waterfall colormap.
// No dependencies; every other file in hdl/ refers to it by scoped names.
`default_nettype none

package wfc_pkg;

  localparam int LVL_W     = 16;
  localparam int FRAC_W    = 16;
  localparam int QUO_W     = FRAC_W + 1;
  localparam int DIV_STEPS = QUO_W;
  localparam int COL_W     = 8;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam logic [COL_W-1:0] COL_MAX = 8'hFF;
  localparam logic [COL_W-1:0] COL_MIN = 8'h00;

  typedef enum logic [1:0] {
    CLS_BLACK,
    CLS_YELLOW,
    CLS_INTERP
  } cls_t;

  typedef enum logic [2:0] {
    SEG_TO_BLUE,
    SEG_TO_CYAN,
    SEG_TO_GREEN,
    SEG_TO_YELLOW,
    SEG_TO_RED,
    SEG_TO_MAGENTA,
    SEG_TO_WHITE
  } seg_t;

  typedef enum logic {
    REG_LOW_LEVEL,
    REG_HIGH_LEVEL
  } reg_idx_t;

  typedef struct packed {
    cls_t              cls;
    logic [FRAC_W-1:0] rem;
    logic [FRAC_W-1:0] dvs;
    logic              nbit;
    logic [QUO_W-1:0]  quo;
  } div_stage_t;

  typedef struct packed {
    cls_t             cls;
    logic [QUO_W-1:0] quo;
  } frac_t;

  typedef struct packed {
    cls_t             cls;
    seg_t             seg;
    logic [QUO_W-1:0] loc;
  } seg_pos_t;

  // floor(loc * 255 / 2^16)
  function automatic logic [COL_W-1:0] ramp_up(input logic [QUO_W-1:0] loc);
    logic [QUO_W+COL_W-1:0] p;
    p = {loc, 8'd0} - {8'd0, loc};
    return p[FRAC_W+COL_W-1:FRAC_W];
  endfunction

  function automatic logic [COL_W-1:0] ramp_down(input logic [QUO_W-1:0] loc);
    logic [QUO_W-1:0] inv;
    inv = 17'd65536 - loc;
    return ramp_up(inv);
  endfunction

  // floor(255 * (2^18 - loc) / 2^18)
  function automatic logic [COL_W-1:0] white_red(input logic [QUO_W-1:0] loc);
    logic [18:0] m;
    logic [26:0] p;
    m = 19'd262144 - {2'b00, loc};
    p = {m, 8'd0} - {8'd0, m};
    return p[25:18];
  endfunction

  // floor(loc * 255 / 2^17)
  function automatic logic [COL_W-1:0] white_green(input logic [QUO_W-1:0] loc);
    logic [QUO_W+COL_W-1:0] p;
    p = {loc, 8'd0} - {8'd0, loc};
    return p[24:17];
  endfunction

endpackage

`default_nettype wire

[hdl/wfc_stream_if.sv]
// Valid/ready stream interfaces for level items in and pixel items out.
// Depends on wfc_pkg for field widths.
`default_nettype none

interface wfc_level_if;
  logic                                valid;
  logic                                ready;
  logic signed [wfc_pkg::LVL_W-1:0]    level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

interface wfc_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [wfc_pkg::COL_W-1:0]  red;
  logic [wfc_pkg::COL_W-1:0]  green;
  logic [wfc_pkg::COL_W-1:0]  blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

[hdl/waterfall_level_to_rgb_core.sv]
// Waterfall colormap: one signed Q12.4 level item in, one RGB pixel item out.
// Accepts one item per cycle; an item passes an entry stage, a 17-stage
// one-bit-per-stage divider for the position between the thresholds, a segment
// stage and an output register. Input ready drops only while the output skid holds
// an item, so a stalled output costs no accepted item. Thresholds come from an
// APB port (low_level at 0x0, high_level at 0x4) and may be written when idle.
// Depends on wfc_pkg, wfc_stream_if, wfc_apb_regs, wfc_divider, wfc_colormap.
`default_nettype none

module waterfall_level_to_rgb_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  wfc_level_if.sink                        in_if,
  wfc_pixel_if.source                      out_if,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [wfc_pkg::APB_AW-1:0]  paddr,
  input  wire logic [wfc_pkg::APB_DW-1:0]  pwdata,
  output logic      [wfc_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);

  logic signed [wfc_pkg::LVL_W-1:0] low_level;
  logic signed [wfc_pkg::LVL_W-1:0] high_level;
  logic                             pipe_en;
  logic                             frac_valid;
  wfc_pkg::frac_t                   frac;

  wfc_apb_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .low_level  (low_level),
    .high_level (high_level)
  );

  wfc_divider u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (pipe_en),
    .in_valid   (in_if.valid),
    .level      (in_if.level),
    .low_level  (low_level),
    .high_level (high_level),
    .out_valid  (frac_valid),
    .out_frac   (frac)
  );

  wfc_colormap u_cmap (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (frac_valid),
    .in_frac   (frac),
    .pipe_en   (pipe_en),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .red       (out_if.red),
    .green     (out_if.green),
    .blue      (out_if.blue)
  );

  assign in_if.ready = pipe_en;

  a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |-> out_if.valid)
    else $error("pipeline stalled with no output item pending");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(pipe_en) |-> $past(out_if.valid && !out_if.ready))
    else $error("pipeline stall began without a blocked output");

  a_stall_short: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en && out_if.ready |=> pipe_en)
    else $error("skid not drained after output accepted");

endmodule

`default_nettype wire

[hdl/wfc_apb_regs.sv]
// APB register file holding the low and high threshold levels.
// Depends on wfc_pkg.
`default_nettype none

module wfc_apb_regs (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [wfc_pkg::APB_AW-1:0]       paddr,
  input  wire logic [wfc_pkg::APB_DW-1:0]       pwdata,
  output logic      [wfc_pkg::APB_DW-1:0]       prdata,
  output logic                                  pready,
  output logic signed [wfc_pkg::LVL_W-1:0]      low_level,
  output logic signed [wfc_pkg::LVL_W-1:0]      high_level
);

  logic signed [wfc_pkg::LVL_W-1:0] low_r;
  logic signed [wfc_pkg::LVL_W-1:0] high_r;
  logic                             wr_en;
  wfc_pkg::reg_idx_t                idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = wfc_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= 16'sd480;
      high_r <= 16'sd1440;
    end else if (wr_en) begin
      case (idx)
        wfc_pkg::REG_LOW_LEVEL:  low_r  <= pwdata[wfc_pkg::LVL_W-1:0];
        wfc_pkg::REG_HIGH_LEVEL: high_r <= pwdata[wfc_pkg::LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      wfc_pkg::REG_LOW_LEVEL:  prdata = {{(wfc_pkg::APB_DW-wfc_pkg::LVL_W){low_r[15]}}, low_r};
      wfc_pkg::REG_HIGH_LEVEL: prdata = {{(wfc_pkg::APB_DW-wfc_pkg::LVL_W){high_r[15]}}, high_r};
      default:                 prdata = '0;
    endcase
  end

  assign low_level  = low_r;
  assign high_level = high_r;

endmodule

`default_nettype wire

[hdl/wfc_divider.sv]
// Entry stage (classify, offset, range) and pipelined restoring divider
// giving the Q1.16 position of the level between the thresholds. Uses wfc_pkg.
`default_nettype none

module wfc_divider (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           en,
  input  wire logic                           in_valid,
  input  wire logic signed [wfc_pkg::LVL_W-1:0] level,
  input  wire logic signed [wfc_pkg::LVL_W-1:0] low_level,
  input  wire logic signed [wfc_pkg::LVL_W-1:0] high_level,
  output logic                                out_valid,
  output wfc_pkg::frac_t                      out_frac
);

  localparam int N = wfc_pkg::DIV_STEPS;

  function automatic wfc_pkg::div_stage_t mk_entry(
    input logic signed [wfc_pkg::LVL_W-1:0] lv,
    input logic signed [wfc_pkg::LVL_W-1:0] lo,
    input logic signed [wfc_pkg::LVL_W-1:0] hi
  );
    logic [wfc_pkg::LVL_W:0] off;
    logic [wfc_pkg::LVL_W:0] rng;
    wfc_pkg::div_stage_t     s;
    off = {lv[15], lv} - {lo[15], lo};
    rng = {hi[15], hi} - {lo[15], lo};
    if (lv < lo)
      s.cls = wfc_pkg::CLS_BLACK;
    else if (lv > hi)
      s.cls = wfc_pkg::CLS_YELLOW;
    else if (rng[wfc_pkg::FRAC_W-1:0] == '0)
      s.cls = wfc_pkg::CLS_BLACK;
    else
      s.cls = wfc_pkg::CLS_INTERP;
    s.rem  = {1'b0, off[wfc_pkg::FRAC_W-1:1]};
    s.nbit = off[0];
    s.dvs  = rng[wfc_pkg::FRAC_W-1:0];
    s.quo  = '0;
    return s;
  endfunction

  // one quotient bit: shift in the next dividend bit, compare, subtract
  function automatic wfc_pkg::div_stage_t div_step(input wfc_pkg::div_stage_t s);
    logic [wfc_pkg::FRAC_W:0]   t;
    logic [wfc_pkg::FRAC_W:0]   d;
    logic                       qb;
    wfc_pkg::div_stage_t        o;
    t  = {s.rem, s.nbit};
    d  = {1'b0, s.dvs};
    qb = (t >= d);
    o  = s;
    if (qb)
      o.rem = t[wfc_pkg::FRAC_W-1:0] - s.dvs;
    else
      o.rem = t[wfc_pkg::FRAC_W-1:0];
    o.nbit = 1'b0;
    o.quo  = {s.quo[wfc_pkg::QUO_W-2:0], qb};
    return o;
  endfunction

  logic [N:0]          vld_r;
  wfc_pkg::div_stage_t stg_r   [0:N];
  wfc_pkg::div_stage_t stg_nxt [0:N];

  assign stg_nxt[0] = mk_entry(level, low_level, high_level);

  for (genvar k = 1; k <= N; k++) begin : g_step
    assign stg_nxt[k] = div_step(stg_r[k-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= N; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign out_valid    = vld_r[N];
  assign out_frac.cls = stg_r[N].cls;
  assign out_frac.quo = stg_r[N].quo;

endmodule

`default_nettype wire

[hdl/wfc_colormap.sv]
// Segment select stage, combinational color interpolation, output register and skid.
// Produces the pipeline enable for the upstream stages. Uses wfc_pkg.
`default_nettype none

module wfc_colormap (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire wfc_pkg::frac_t            in_frac,
  output logic                           pipe_en,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [wfc_pkg::COL_W-1:0]      red,
  output logic [wfc_pkg::COL_W-1:0]      green,
  output logic [wfc_pkg::COL_W-1:0]      blue
);

  localparam int CW = wfc_pkg::COL_W;

  logic              pos_valid_r;
  wfc_pkg::seg_pos_t pos_r;
  wfc_pkg::seg_pos_t pos_nxt;
  logic [19:0]       p9;
  logic [3:0]        ipart;

  logic [3*CW-1:0]   pix;
  logic [3*CW-1:0]   out_pix_r;
  logic [3*CW-1:0]   skid_pix_r;
  logic              out_valid_r;
  logic              skid_valid_r;

  assign pipe_en = ~skid_valid_r;

  assign p9    = {3'b000, in_frac.quo} + {in_frac.quo, 3'b000};
  assign ipart = p9[19:16];

  always_comb begin
    pos_nxt.cls = in_frac.cls;
    case (ipart)
      4'd0, 4'd1: begin
        pos_nxt.seg = wfc_pkg::SEG_TO_BLUE;
        pos_nxt.loc = {1'b0, ipart[0], p9[15:1]};
      end
      4'd2: begin
        pos_nxt.seg = wfc_pkg::SEG_TO_CYAN;
        pos_nxt.loc = {1'b0, p9[15:0]};
      end
      4'd3: begin
        pos_nxt.seg = wfc_pkg::SEG_TO_GREEN;
        pos_nxt.loc = {1'b0, p9[15:0]};
      end
      4'd4: begin
        pos_nxt.seg = wfc_pkg::SEG_TO_YELLOW;
        pos_nxt.loc = {1'b0, p9[15:0]};
      end
      4'd5, 4'd6: begin
        pos_nxt.seg = wfc_pkg::SEG_TO_RED;
        pos_nxt.loc = {1'b0, (ipart == 4'd6), p9[15:1]};
      end
      4'd7: begin
        pos_nxt.seg = wfc_pkg::SEG_TO_MAGENTA;
        pos_nxt.loc = {1'b0, p9[15:0]};
      end
      4'd8, 4'd9: begin
        pos_nxt.seg = wfc_pkg::SEG_TO_WHITE;
        pos_nxt.loc = {ipart[0], p9[15:0]};
      end
      default: begin
        pos_nxt.seg = wfc_pkg::SEG_TO_WHITE;
        pos_nxt.loc = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_valid_r <= 1'b0;
    end else if (pipe_en) begin
      pos_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pos_r <= pos_nxt;
    end
  end

  always_comb begin
    case (pos_r.cls)
      wfc_pkg::CLS_BLACK:  pix = {wfc_pkg::COL_MIN, wfc_pkg::COL_MIN, wfc_pkg::COL_MIN};
      wfc_pkg::CLS_YELLOW: pix = {wfc_pkg::COL_MAX, wfc_pkg::COL_MAX, wfc_pkg::COL_MIN};
      wfc_pkg::CLS_INTERP: begin
        case (pos_r.seg)
          wfc_pkg::SEG_TO_BLUE:
            pix = {wfc_pkg::COL_MIN, wfc_pkg::COL_MIN, wfc_pkg::ramp_up(pos_r.loc)};
          wfc_pkg::SEG_TO_CYAN:
            pix = {wfc_pkg::COL_MIN, wfc_pkg::ramp_up(pos_r.loc), wfc_pkg::COL_MAX};
          wfc_pkg::SEG_TO_GREEN:
            pix = {wfc_pkg::COL_MIN, wfc_pkg::COL_MAX, wfc_pkg::ramp_down(pos_r.loc)};
          wfc_pkg::SEG_TO_YELLOW:
            pix = {wfc_pkg::ramp_up(pos_r.loc), wfc_pkg::COL_MAX, wfc_pkg::COL_MIN};
          wfc_pkg::SEG_TO_RED:
            pix = {wfc_pkg::COL_MAX, wfc_pkg::ramp_down(pos_r.loc), wfc_pkg::COL_MIN};
          wfc_pkg::SEG_TO_MAGENTA:
            pix = {wfc_pkg::COL_MAX, wfc_pkg::COL_MIN, wfc_pkg::ramp_up(pos_r.loc)};
          wfc_pkg::SEG_TO_WHITE:
            pix = {wfc_pkg::white_red(pos_r.loc), wfc_pkg::white_green(pos_r.loc),
                   wfc_pkg::COL_MAX};
          default:
            pix = {wfc_pkg::COL_MIN, wfc_pkg::COL_MIN, wfc_pkg::COL_MIN};
        endcase
      end
      default: pix = {wfc_pkg::COL_MIN, wfc_pkg::COL_MIN, wfc_pkg::COL_MIN};
    endcase
  end

  // output register; park an item in the skid when the output is stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      out_valid_r  <= skid_valid_r | pos_valid_r;
      skid_valid_r <= 1'b0;
    end else if (pipe_en && pos_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      out_pix_r <= skid_valid_r ? skid_pix_r : pix;
    end else if (pipe_en && pos_valid_r) begin
      skid_pix_r <= pix;
    end
  end

  assign out_valid = out_valid_r;
  assign red       = out_pix_r[3*CW-1:2*CW];
  assign green     = out_pix_r[2*CW-1:CW];
  assign blue      = out_pix_r[CW-1:0];

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking bench for waterfall_level_to_rgb_core: streams level items,
// predicts each RGB pixel in a scoreboard and checks the output stream.
// Depends on wfc_pkg and the stream interfaces in wfc_stream_if.
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [wfc_pkg::COL_W-1:0] red;
    logic [wfc_pkg::COL_W-1:0] green;
    logic [wfc_pkg::COL_W-1:0] blue;
  } pixel_t;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  class pixel_scoreboard;
    logic signed [wfc_pkg::LVL_W-1:0] low_lvl;
    logic signed [wfc_pkg::LVL_W-1:0] high_lvl;
    pixel_t                           pixel_q[$];
    int                               errors;

    function new();
      low_lvl  = 16'sd480;
      high_lvl = 16'sd1440;
      errors   = 0;
    endfunction

    function void set_threshold(wfc_pkg::reg_idx_t idx, logic [wfc_pkg::LVL_W-1:0] v);
      if (idx == wfc_pkg::REG_LOW_LEVEL) low_lvl = v;
      else high_lvl = v;
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction

    function logic [wfc_pkg::COL_W-1:0] ramp_rise(longint unsigned loc);
      return wfc_pkg::COL_W'((loc * 255) >> 16);
    endfunction

    function logic [wfc_pkg::COL_W-1:0] ramp_fall(longint unsigned loc);
      return wfc_pkg::COL_W'(((65536 - loc) * 255) >> 16);
    endfunction

    function pixel_t color_of(logic signed [wfc_pkg::LVL_W-1:0] lv);
      int              l;
      int              lo;
      int              hi;
      longint unsigned span;
      longint unsigned offs;
      longint unsigned pct;
      longint unsigned p9;
      longint unsigned loc;
      longint unsigned base;
      longint unsigned w;
      wfc_pkg::seg_t   seg;
      pixel_t          px;
      l  = lv;
      lo = low_lvl;
      hi = high_lvl;
      px = '0;
      if (l < lo) return px;
      if (l > hi) begin
        px.red   = wfc_pkg::COL_MAX;
        px.green = wfc_pkg::COL_MAX;
        return px;
      end
      span = longint'(hi - lo);
      offs = longint'(l - lo);
      if (span == 0) return px;
      pct = (offs * 65536) / span;
      p9  = pct * 9;
      if (p9 < 2 * 65536) begin
        seg = wfc_pkg::SEG_TO_BLUE;    base = 0; w = 2;
      end else if (p9 < 3 * 65536) begin
        seg = wfc_pkg::SEG_TO_CYAN;    base = 2; w = 1;
      end else if (p9 < 4 * 65536) begin
        seg = wfc_pkg::SEG_TO_GREEN;   base = 3; w = 1;
      end else if (p9 < 5 * 65536) begin
        seg = wfc_pkg::SEG_TO_YELLOW;  base = 4; w = 1;
      end else if (p9 < 7 * 65536) begin
        seg = wfc_pkg::SEG_TO_RED;     base = 5; w = 2;
      end else if (p9 < 8 * 65536) begin
        seg = wfc_pkg::SEG_TO_MAGENTA; base = 7; w = 1;
      end else begin
        seg = wfc_pkg::SEG_TO_WHITE;   base = 8; w = 1;
      end
      loc = (p9 - base * 65536) / w;
      if (loc > 65536) loc = 65536;
      case (seg)
        wfc_pkg::SEG_TO_BLUE:
          px = '{wfc_pkg::COL_MIN, wfc_pkg::COL_MIN, ramp_rise(loc)};
        wfc_pkg::SEG_TO_CYAN:
          px = '{wfc_pkg::COL_MIN, ramp_rise(loc), wfc_pkg::COL_MAX};
        wfc_pkg::SEG_TO_GREEN:
          px = '{wfc_pkg::COL_MIN, wfc_pkg::COL_MAX, ramp_fall(loc)};
        wfc_pkg::SEG_TO_YELLOW:
          px = '{ramp_rise(loc), wfc_pkg::COL_MAX, wfc_pkg::COL_MIN};
        wfc_pkg::SEG_TO_RED:
          px = '{wfc_pkg::COL_MAX, ramp_fall(loc), wfc_pkg::COL_MIN};
        wfc_pkg::SEG_TO_MAGENTA:
          px = '{wfc_pkg::COL_MAX, wfc_pkg::COL_MIN, ramp_rise(loc)};
        default: begin
          px.red   = wfc_pkg::COL_W'((255 * (262144 - loc)) / 262144);
          px.green = wfc_pkg::COL_W'((loc * 255) >> 17);
          px.blue  = wfc_pkg::COL_MAX;
        end
      endcase
      return px;
    endfunction

    function void note_level(logic signed [wfc_pkg::LVL_W-1:0] lv);
      pixel_q.push_back(color_of(lv));
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_pixel(pixel_t got);
      pixel_t want;
      if (pixel_q.size() == 0) begin
        report($sformatf("pixel %0d/%0d/%0d with no item pending",
                         got.red, got.green, got.blue));
        return;
      end
      want = pixel_q.pop_front();
      if (got.red !== want.red)
        report($sformatf("red got %0d expected %0d", got.red, want.red));
      if (got.green !== want.green)
        report($sformatf("green got %0d expected %0d", got.green, want.green));
      if (got.blue !== want.blue)
        report($sformatf("blue got %0d expected %0d", got.blue, want.blue));
    endtask
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_psel;
  logic                       cfg_penable;
  logic                       cfg_pwrite;
  logic [wfc_pkg::APB_AW-1:0] cfg_paddr;
  logic [wfc_pkg::APB_DW-1:0] cfg_pwdata;
  logic [wfc_pkg::APB_DW-1:0] cfg_prdata;
  logic                       cfg_pready;

  idle_mode_t        idle_mode;
  int                cycles;
  pixel_scoreboard   sb;

  wfc_level_if lvl_if ();
  wfc_pixel_if pix_if ();

  waterfall_level_to_rgb_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (lvl_if),
    .out_if  (pix_if),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function int send_idle_pct();
    case (idle_mode)
      IDLE_SEND: return 55;
      IDLE_BOTH: return 15;
      default:   return 0;
    endcase
  endfunction

  function int recv_stall_pct();
    case (idle_mode)
      IDLE_RECV: return 55;
      IDLE_BOTH: return 15;
      default:   return 0;
    endcase
  endfunction

  always @(negedge clk) begin
    pix_if.ready <= ($urandom_range(99) >= recv_stall_pct());
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (pix_if.valid && pix_if.ready)
        sb.check_pixel(pixel_t'{pix_if.red, pix_if.green, pix_if.blue});
      if (lvl_if.valid && lvl_if.ready)
        sb.note_level(lvl_if.level);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("waterfall_level_to_rgb_core test failed");
      $finish;
    end
  end

  // Called at a falling edge; returns at a falling edge with valid still high.
  task send_level(input int v);
    while ($urandom_range(99) < send_idle_pct()) begin
      lvl_if.valid <= 1'b0;
      @(negedge clk);
    end
    lvl_if.valid <= 1'b1;
    lvl_if.level <= wfc_pkg::LVL_W'(v);
    do @(posedge clk); while (!lvl_if.ready);
    @(negedge clk);
  endtask

  task drain_pixels();
    lvl_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  task cfg_access(input wfc_pkg::reg_idx_t idx, input logic wr,
                  input logic [wfc_pkg::LVL_W-1:0] v,
                  output logic [wfc_pkg::APB_DW-1:0] rd);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= wfc_pkg::APB_AW'({idx, 2'b00});
    cfg_pwdata  <= {16'($urandom), v};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rd = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task cfg_check(input wfc_pkg::reg_idx_t idx);
    logic [wfc_pkg::APB_DW-1:0] rd;
    logic [wfc_pkg::LVL_W-1:0]  want;
    cfg_access(idx, 1'b0, '0, rd);
    want = (idx == wfc_pkg::REG_LOW_LEVEL) ? sb.low_lvl : sb.high_lvl;
    if (rd[wfc_pkg::LVL_W-1:0] !== want)
      sb.report($sformatf("register %s read %0h expected %0h", idx.name(),
                          rd[wfc_pkg::LVL_W-1:0], want));
  endtask

  task set_thresholds(input int lo, input int hi);
    logic [wfc_pkg::APB_DW-1:0] rd;
    drain_pixels();
    repeat (24) @(negedge clk);
    cfg_access(wfc_pkg::REG_LOW_LEVEL, 1'b1, wfc_pkg::LVL_W'(lo), rd);
    sb.set_threshold(wfc_pkg::REG_LOW_LEVEL, wfc_pkg::LVL_W'(lo));
    cfg_access(wfc_pkg::REG_HIGH_LEVEL, 1'b1, wfc_pkg::LVL_W'(hi), rd);
    sb.set_threshold(wfc_pkg::REG_HIGH_LEVEL, wfc_pkg::LVL_W'(hi));
    cfg_check(wfc_pkg::REG_LOW_LEVEL);
    cfg_check(wfc_pkg::REG_HIGH_LEVEL);
  endtask

  function int pick_level(int lo, int hi);
    int a;
    int b;
    int v;
    int sel;
    a   = (lo < hi) ? lo : hi;
    b   = (lo < hi) ? hi : lo;
    sel = $urandom_range(99);
    if (sel < 70)
      v = a + int'($urandom_range(b - a));
    else if (sel < 85)
      v = ($urandom_range(1) ? lo : hi) + int'($urandom_range(8)) - 4;
    else
      v = int'($urandom_range(65535)) - 32768;
    if (v < -32768) v = -32768;
    if (v > 32767) v = 32767;
    return v;
  endfunction

  task send_random(input int n, input int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) drain_pixels();
      send_level(pick_level(sb.low_lvl, sb.high_lvl));
    end
  endtask

  int dir_levels[$];
  int lo_r;
  int hi_r;

  initial begin
    sb                = new();
    idle_mode         = IDLE_NONE;
    rst_n             = 1'b0;
    lvl_if.valid      = 1'b0;
    lvl_if.level      = '0;
    cfg_psel          = 1'b0;
    cfg_penable       = 1'b0;
    cfg_pwrite        = 1'b0;
    cfg_paddr         = '0;
    cfg_pwdata        = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    cfg_check(wfc_pkg::REG_LOW_LEVEL);
    cfg_check(wfc_pkg::REG_HIGH_LEVEL);

    // reset thresholds: both edges of every segment, thresholds, extremes
    dir_levels = '{479, 480, 693, 694, 800, 801, 906, 907, 1013, 1014, 1226, 1227,
                   1333, 1334, 1439, 1440, 1441, -32768, 32767, 0, -1};
    foreach (dir_levels[i]) send_level(dir_levels[i]);
    send_random(300, 150);

    idle_mode = IDLE_SEND;
    set_thresholds(-32768, 32767);
    dir_levels = '{-32768, 32767, 0, -1};
    foreach (dir_levels[i]) send_level(dir_levels[i]);
    send_random(300, -1);

    // zero range
    idle_mode = IDLE_RECV;
    set_thresholds(100, 100);
    dir_levels = '{99, 100, 101};
    foreach (dir_levels[i]) send_level(dir_levels[i]);
    send_random(200, -1);

    // low above high
    idle_mode = IDLE_BOTH;
    set_thresholds(1000, -1000);
    send_random(200, -1);

    idle_mode = IDLE_NONE;
    set_thresholds(-5, -4);
    send_random(150, -1);

    for (int k = 0; k < 4; k++) begin
      idle_mode = idle_mode_t'(k);
      if (k == 3) begin
        lo_r = int'($urandom_range(65535)) - 32768;
        hi_r = int'($urandom_range(65535)) - 32768;
      end else begin
        lo_r = int'($urandom_range(4000)) - 2000;
        hi_r = lo_r + int'($urandom_range(3000));
      end
      set_thresholds(lo_r, hi_r);
      send_random(200, -1);
    end

    drain_pixels();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("waterfall_level_to_rgb_core test passed");
    else
      $display("waterfall_level_to_rgb_core test failed");
    $finish;
  end

endmodule

[files.f]
hdl/wfc_pkg.sv
hdl/wfc_stream_if.sv
hdl/wfc_apb_regs.sv
hdl/wfc_divider.sv
hdl/wfc_colormap.sv
hdl/waterfall_level_to_rgb_core.sv
tb/tb_top.sv
